[hw/rtl/wsc_pkg.sv]
// shared types, codes and constants for the wavetable sound channel
package wsc_pkg;

  localparam int unsigned RAM_DEPTH   = 16;
  localparam int unsigned ADDR_W      = 4;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned NIBBLE_W    = 4;
  localparam int unsigned INDEX_W     = 5;
  localparam int unsigned FREQ_W      = 11;
  localparam int unsigned PERIOD_W    = 12;
  localparam int unsigned LENGTH_W    = 9;
  localparam int unsigned OP_W        = 3;
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 11;

  // event codes
  localparam logic [OP_W-1:0] OP_TICK      = 3'd0;
  localparam logic [OP_W-1:0] OP_LENGTH    = 3'd1;
  localparam logic [OP_W-1:0] OP_TRIGGER   = 3'd2;
  localparam logic [OP_W-1:0] OP_RAM_READ  = 3'd3;
  localparam logic [OP_W-1:0] OP_RAM_WRITE = 3'd4;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_DAC_ENABLE    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_VOLUME_CODE   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_FREQUENCY     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_LENGTH_ENABLE = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_COLOR_MODEL   = 3'd4;

  // output level codes
  localparam logic [1:0] VOL_MUTE    = 2'd0;
  localparam logic [1:0] VOL_FULL    = 2'd1;
  localparam logic [1:0] VOL_HALF    = 2'd2;
  localparam logic [1:0] VOL_QUARTER = 2'd3;

  localparam logic [PERIOD_W-1:0] PERIOD_BASE   = 12'd2048;
  localparam logic [PERIOD_W-1:0] TRIGGER_EXTRA = 12'd2;
  localparam logic [LENGTH_W-1:0] LENGTH_FULL   = 9'd256;
  localparam logic [LENGTH_W-1:0] LENGTH_SHORT  = 9'd255;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] address;
    logic [BYTE_W-1:0] bus_data;
    logic              frame_phase_odd;
  } item_t;

  typedef struct packed {
    logic [NIBBLE_W-1:0] sample;
    logic [BYTE_W-1:0]   read_data;
    logic                channel_on;
  } result_t;

  // right shift applied for each volume code: mute, full, half, quarter
  function automatic logic [2:0] vol_shift(input logic [1:0] code);
    logic [2:0] sh;
    case (code)
      VOL_MUTE: sh = 3'd4;
      VOL_FULL: sh = 3'd0;
      VOL_HALF: sh = 3'd1;
      default:  sh = 3'd2;
    endcase
    return sh;
  endfunction

endpackage

[hw/rtl/wavetable_sound_channel.sv]
// wavetable sound channel: 32 four-bit samples in a 16-byte wave ram, one event per request
// an accepted request has its result in the output register in the following cycle
// throughput: one request per cycle while the held result is not stalled downstream
// all event logic sits between the channel state and the result register
// reset: synchronous, resets configuration, channel state and the whole wave ram
// the input is stalled only while a held result is itself stalled downstream
module wavetable_sound_channel (
  input  logic                                clk,
  input  logic                                rst,
  // event requests
  input  logic                                item_valid,
  output logic                                item_stall,
  input  wsc_pkg::item_t                      item,
  // results, one per event
  output logic                                result_valid,
  input  logic                                result_stall,
  output wsc_pkg::result_t                    result,
  // configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [wsc_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [wsc_pkg::CFG_DATA_W-1:0]      cfg_data
);

  // configuration registers
  logic                           dac_enable;
  logic [1:0]                     volume_code;
  logic [wsc_pkg::FREQ_W-1:0]     frequency;
  logic                           length_enable;
  logic                           color_model;

  // channel state
  logic                           channel_enabled, channel_enabled_next;
  logic [wsc_pkg::PERIOD_W-1:0]   period_count, period_count_next;
  logic [wsc_pkg::INDEX_W-1:0]    sample_index, sample_index_next;
  logic [wsc_pkg::NIBBLE_W-1:0]   latched_sample, latched_sample_next;
  logic                           hold_flag, hold_flag_next;
  logic [wsc_pkg::LENGTH_W-1:0]   length_count, length_count_next;
  logic [wsc_pkg::NIBBLE_W-1:0]   output_level, output_level_next;

  // wave ram, kept in flops: a trigger on the older model rewrites up to four bytes at once
  logic [wsc_pkg::BYTE_W-1:0]     wave_ram      [wsc_pkg::RAM_DEPTH];
  logic [wsc_pkg::BYTE_W-1:0]     wave_ram_next [wsc_pkg::RAM_DEPTH];

  logic                           accept;
  logic                           blocked;
  logic [wsc_pkg::ADDR_W-1:0]     cur_byte;
  logic [wsc_pkg::BYTE_W-1:0]     fetch_byte;
  logic [wsc_pkg::BYTE_W-1:0]     read_data_next;
  logic [wsc_pkg::NIBBLE_W-1:0]   shifted;

  // the result register frees up whenever it is empty or being taken
  assign item_stall = result_valid & result_stall;
  assign accept     = item_valid & ~item_stall;
  assign cfg_ready  = 1'b1;

  // older model blocks ram access while playing unless the hold flag is up
  assign blocked  = ~color_model & ~hold_flag;
  assign cur_byte = sample_index[wsc_pkg::INDEX_W-1:1];

  // configuration write decode; indexes beyond the list are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      dac_enable    <= 1'b0;
      volume_code   <= 2'd0;
      frequency     <= '0;
      length_enable <= 1'b0;
      color_model   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        wsc_pkg::CFG_DAC_ENABLE:    dac_enable    <= cfg_data[0];
        wsc_pkg::CFG_VOLUME_CODE:   volume_code   <= cfg_data[1:0];
        wsc_pkg::CFG_FREQUENCY:     frequency     <= cfg_data[wsc_pkg::FREQ_W-1:0];
        wsc_pkg::CFG_LENGTH_ENABLE: length_enable <= cfg_data[0];
        wsc_pkg::CFG_COLOR_MODEL:   color_model   <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // event logic: next channel state and the result of this request
  always_comb begin
    channel_enabled_next = channel_enabled;
    period_count_next    = period_count;
    sample_index_next    = sample_index;
    latched_sample_next  = latched_sample;
    hold_flag_next       = hold_flag;
    length_count_next    = length_count;
    output_level_next    = output_level;
    wave_ram_next        = wave_ram;
    read_data_next       = '0;
    fetch_byte           = '0;
    shifted              = '0;

    case (item.op)
      wsc_pkg::OP_TICK: begin
        hold_flag_next = 1'b0;
        if (period_count != '0) begin
          if (period_count == wsc_pkg::PERIOD_W'(1)) begin
            // period expired: reload, step to the next sample and latch it
            period_count_next   = wsc_pkg::PERIOD_BASE - {1'b0, frequency};
            sample_index_next   = sample_index + 1'b1;
            fetch_byte          = wave_ram[sample_index_next[wsc_pkg::INDEX_W-1:1]];
            latched_sample_next = sample_index_next[0] ? fetch_byte[3:0] : fetch_byte[7:4];
            hold_flag_next      = 1'b1;
          end else begin
            period_count_next = period_count - 1'b1;
          end
        end
        // mute shifts everything out
        shifted           = latched_sample_next >> wsc_pkg::vol_shift(volume_code);
        output_level_next = channel_enabled ? shifted : '0;
      end

      wsc_pkg::OP_LENGTH: begin
        if (length_enable && length_count != '0) begin
          length_count_next = length_count - 1'b1;
          if (length_count == wsc_pkg::LENGTH_W'(1)) begin
            channel_enabled_next = 1'b0;
          end
        end
      end

      wsc_pkg::OP_TRIGGER: begin
        // older model retriggered right after a sample fetch corrupts the first bytes
        if (!color_model && hold_flag) begin
          if (cur_byte[3:2] == 2'b00) begin
            wave_ram_next[0] = wave_ram[cur_byte];
          end else begin
            for (int k = 0; k < 4; k++) begin
              wave_ram_next[k] = wave_ram[{cur_byte[3:2], 2'(k)}];
            end
          end
        end
        channel_enabled_next = dac_enable;
        period_count_next    = wsc_pkg::PERIOD_BASE - {1'b0, frequency}
                               + wsc_pkg::TRIGGER_EXTRA;
        sample_index_next    = '0;
        latched_sample_next  = '0;
        hold_flag_next       = 1'b0;
        if (length_count == '0) begin
          length_count_next = (item.frame_phase_odd && length_enable) ?
                              wsc_pkg::LENGTH_SHORT : wsc_pkg::LENGTH_FULL;
        end
      end

      wsc_pkg::OP_RAM_READ: begin
        if (channel_enabled) begin
          read_data_next = blocked ? item.bus_data : wave_ram[cur_byte];
        end else begin
          read_data_next = wave_ram[item.address];
        end
      end

      wsc_pkg::OP_RAM_WRITE: begin
        // while playing the access lands on the byte being played, and is dropped while blocked
        if (channel_enabled) begin
          if (!blocked) begin
            wave_ram_next[cur_byte] = item.bus_data;
          end
        end else begin
          wave_ram_next[item.address] = item.bus_data;
        end
      end

      default: begin
      end
    endcase
  end

  // state update on each accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_enabled <= 1'b0;
      period_count    <= '0;
      sample_index    <= '0;
      latched_sample  <= '0;
      hold_flag       <= 1'b0;
      length_count    <= wsc_pkg::LENGTH_FULL;
      output_level    <= '0;
      for (int i = 0; i < wsc_pkg::RAM_DEPTH; i++) begin
        wave_ram[i] <= '0;
      end
    end else if (accept) begin
      channel_enabled <= channel_enabled_next;
      period_count    <= period_count_next;
      sample_index    <= sample_index_next;
      latched_sample  <= latched_sample_next;
      hold_flag       <= hold_flag_next;
      length_count    <= length_count_next;
      output_level    <= output_level_next;
      wave_ram        <= wave_ram_next;
    end
  end

  // result register valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // result payload, loaded only with a new request
  always_ff @(posedge clk) begin
    if (accept) begin
      result.sample     <= output_level_next;
      result.read_data  <= read_data_next;
      result.channel_on <= channel_enabled_next;
    end
  end

endmodule
